// ----- rtl/awb_pkg.sv -----
// Package: shared constants, types and helpers of the affine warp block.
`default_nettype none
package awb_pkg;
  localparam int MAX_WIDTH_DEF  = 256;
  localparam int MAX_HEIGHT_DEF = 256;
  localparam int CHANNELS_DEF   = 3;
  localparam int NCH            = 4;
  localparam int CFG_IDX_W      = 3;
  localparam int CFG_DATA_W     = 32;
  localparam int COORD_W        = 12;
  localparam int DIM_W          = 9;
  localparam int WEIGHT_W       = 12;
  localparam int BLEND_SHIFT    = 22;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_COEF_XX    = 3'd0,
    REG_COEF_XY    = 3'd1,
    REG_COEF_XO    = 3'd2,
    REG_COEF_YX    = 3'd3,
    REG_COEF_YY    = 3'd4,
    REG_COEF_YO    = 3'd5,
    REG_SRC_WIDTH  = 3'd6,
    REG_SRC_HEIGHT = 3'd7
  } cfg_reg_t;

  typedef enum logic {
    MODE_LOAD    = 1'b0,
    MODE_REQUEST = 1'b1
  } mode_t;

  // Lower-neighbour weight: round((65536 - f) / 32), in 0..2048.
  function automatic logic [WEIGHT_W-1:0] near_weight(input logic [15:0] frac);
    logic [17:0] t;
    t = 18'd65536 - {2'b00, frac} + 18'd16;
    return t[16:5];
  endfunction
endpackage
`default_nettype wire

// ----- rtl/affine_warp_bilinear.sv -----
// Top level: affine warp with bilinear interpolation over a banked pixel store.
// The block keeps a source image of up to MAX_WIDTH x MAX_HEIGHT pixels in four
// banks split by x/y parity, so the four neighbours of a source point come out
// of one store read. Load beats (mode 0) write a pixel; request beats (mode 1)
// map (dx,dy) through the Q15.16 affine matrix and return one blended pixel.
// Throughput is one beat per clock while the output is not stalled; a request's
// result passes seven register stages (product, sum, floor/bound, store read,
// horizontal blend, vertical blend, output register). The whole pipeline
// advances together and holds while the output is stalled with a result waiting,
// so nothing is dropped or repeated. Loads travel three stages and write the
// store at the point where requests read it, so reads and writes keep beat
// order; a pixel must be loaded before a request uses it. The store is not
// cleared at reset. Configure only while no request is in flight.
`default_nettype none
module affine_warp_bilinear import awb_pkg::*; #(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = MAX_HEIGHT_DEF,
  parameter int CHANNELS   = CHANNELS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic                  in_mode,
  input  wire logic [COORD_W-1:0]    in_coord_x,
  input  wire logic [COORD_W-1:0]    in_coord_y,
  input  wire logic [7:0]            in_value_0,
  input  wire logic [7:0]            in_value_1,
  input  wire logic [7:0]            in_value_2,
  input  wire logic [7:0]            in_value_3,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic                       out_inside_res,
  output logic [7:0]                 out_out_0,
  output logic [7:0]                 out_out_1,
  output logic [7:0]                 out_out_2,
  output logic [7:0]                 out_out_3
);
  localparam int XW = $clog2(MAX_WIDTH);
  localparam int YW = $clog2(MAX_HEIGHT);
  localparam int PIPE = 4; // store read, blend x, blend y, output
  localparam int LDW = XW + YW + 32;

  // configuration registers
  logic signed [31:0] cxx_r, cxy_r, cxo_r, cyx_r, cyy_r, cyo_r;
  logic [DIM_W-1:0]   sw_r, sh_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cxx_r <= 32'sd65536; cxy_r <= '0; cxo_r <= '0;
      cyx_r <= '0; cyy_r <= 32'sd65536; cyo_r <= '0;
      sw_r  <= DIM_W'(256); sh_r <= DIM_W'(256);
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_COEF_XX:    cxx_r <= cfg_data;
        REG_COEF_XY:    cxy_r <= cfg_data;
        REG_COEF_XO:    cxo_r <= cfg_data;
        REG_COEF_YX:    cyx_r <= cfg_data;
        REG_COEF_YY:    cyy_r <= cfg_data;
        REG_COEF_YO:    cyo_r <= cfg_data;
        REG_SRC_WIDTH:  sw_r  <= cfg_data[DIM_W-1:0];
        REG_SRC_HEIGHT: sh_r  <= cfg_data[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  // advance the whole pipe unless a result waits on a stalled output
  logic adv;
  assign adv      = !(out_valid && out_stall);
  assign in_stall = !adv;

  logic acc_in;
  assign acc_in = in_valid && adv;

  // load path: drop out-of-store coordinates
  logic ld_ok;
  logic [31:0] wr_word;
  assign ld_ok = acc_in && (in_mode == MODE_LOAD)
              && ({1'b0, in_coord_x} < (COORD_W+1)'(MAX_WIDTH))
              && ({1'b0, in_coord_y} < (COORD_W+1)'(MAX_HEIGHT));
  always_comb begin
    wr_word = '0;
    if (CHANNELS > 0) wr_word[7:0]   = in_value_0;
    if (CHANNELS > 1) wr_word[15:8]  = in_value_1;
    if (CHANNELS > 2) wr_word[23:16] = in_value_2;
    if (CHANNELS > 3) wr_word[31:24] = in_value_3;
  end

  // carry loads alongside the map stages; write where requests read
  logic [2:0]     ld_vld_r;
  logic [LDW-1:0] ld_dat_r [3];
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ld_vld_r <= '0;
    end else if (adv) begin
      ld_vld_r <= {ld_vld_r[1:0], ld_ok};
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      ld_dat_r[0] <= {in_coord_x[XW-1:0], in_coord_y[YW-1:0], wr_word};
      ld_dat_r[1] <= ld_dat_r[0];
      ld_dat_r[2] <= ld_dat_r[1];
    end
  end

  // address map
  logic m_vld, m_in;
  logic [XW-1:0] m_sx;
  logic [YW-1:0] m_sy;
  logic [WEIGHT_W-1:0] m_wx0, m_wy0;

  awb_map #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_map (
    .clk, .rst_n, .adv,
    .in_vld(in_valid && in_mode == MODE_REQUEST),
    .dx(in_coord_x), .dy(in_coord_y),
    .coef_xx(cxx_r), .coef_xy(cxy_r), .coef_xo(cxo_r),
    .coef_yx(cyx_r), .coef_yy(cyy_r), .coef_yo(cyo_r),
    .src_width(sw_r), .src_height(sh_r),
    .out_vld(m_vld), .src_hit(m_in), .sx(m_sx), .sy(m_sy),
    .wx0(m_wx0), .wy0(m_wy0)
  );

  logic [31:0] n_lt, n_rt, n_lb, n_rb;
  awb_store #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_store (
    .clk, .adv,
    .wr_en(ld_vld_r[2] && adv),
    .wr_x(ld_dat_r[2][LDW-1 -: XW]), .wr_y(ld_dat_r[2][32 +: YW]),
    .wr_data(ld_dat_r[2][31:0]),
    .rd_x(m_sx), .rd_y(m_sy),
    .lt(n_lt), .rt(n_rt), .lb(n_lb), .rb(n_rb)
  );

  // weights are registered alongside the store read
  logic [WEIGHT_W-1:0] wx0_r, wy0_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      wx0_r <= m_wx0;
      wy0_r <= m_wy0;
    end
  end

  logic [7:0] pix [NCH];
  for (genvar k = 0; k < NCH; k++) begin : g_ch
    awb_blend u_blend (
      .clk, .adv,
      .lt(n_lt[8*k +: 8]), .rt(n_rt[8*k +: 8]),
      .lb(n_lb[8*k +: 8]), .rb(n_rb[8*k +: 8]),
      .wx0(wx0_r), .wy0(wy0_r), .pix(pix[k])
    );
  end

  // valid and inside flags ride along the store/blend stages
  logic [PIPE-2:0] vld_r, ins_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[PIPE-3:0], m_vld};
    end
  end
  always_ff @(posedge clk) begin
    if (adv) ins_r <= {ins_r[PIPE-3:0], m_in};
  end

  // output register; zero channels when outside or unused
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= vld_r[PIPE-2];
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      out_inside_res <= ins_r[PIPE-2];
      out_out_0 <= (ins_r[PIPE-2] && CHANNELS > 0) ? pix[0] : 8'd0;
      out_out_1 <= (ins_r[PIPE-2] && CHANNELS > 1) ? pix[1] : 8'd0;
      out_out_2 <= (ins_r[PIPE-2] && CHANNELS > 2) ? pix[2] : 8'd0;
      out_out_3 <= (ins_r[PIPE-2] && CHANNELS > 3) ? pix[3] : 8'd0;
    end
  end
endmodule
`default_nettype wire

// ----- rtl/awb_map.sv -----
// Address map stages: affine transform, floor split, bounds check, weights.
`default_nettype none
module awb_map import awb_pkg::*; #(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = MAX_HEIGHT_DEF,
  parameter int XW = $clog2(MAX_WIDTH),
  parameter int YW = $clog2(MAX_HEIGHT)
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                adv,
  input  wire logic                in_vld,
  input  wire logic [COORD_W-1:0]  dx,
  input  wire logic [COORD_W-1:0]  dy,
  input  wire logic signed [31:0]  coef_xx,
  input  wire logic signed [31:0]  coef_xy,
  input  wire logic signed [31:0]  coef_xo,
  input  wire logic signed [31:0]  coef_yx,
  input  wire logic signed [31:0]  coef_yy,
  input  wire logic signed [31:0]  coef_yo,
  input  wire logic [DIM_W-1:0]    src_width,
  input  wire logic [DIM_W-1:0]    src_height,
  output logic                     out_vld,
  output logic                     src_hit,
  output logic [XW-1:0]            sx,
  output logic [YW-1:0]            sy,
  output logic [WEIGHT_W-1:0]      wx0,
  output logic [WEIGHT_W-1:0]      wy0
);
  localparam int PW = 46;

  // stage A: four products
  logic              a_vld_r;
  logic signed [PW-1:0] pxx_r, pxy_r, pyx_r, pyy_r;
  logic signed [31:0] cxo_r, cyo_r;
  // stage B: sums
  logic              b_vld_r;
  logic signed [PW-1:0] px_r, py_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
      b_vld_r <= 1'b0;
      out_vld <= 1'b0;
    end else if (adv) begin
      a_vld_r <= in_vld;
      b_vld_r <= a_vld_r;
      out_vld <= b_vld_r;
    end
  end

  logic signed [PW-1:0] px_nxt, py_nxt;
  assign px_nxt = pxx_r + pxy_r + PW'(cxo_r);
  assign py_nxt = pyx_r + pyy_r + PW'(cyo_r);

  // dimension clamp and bounds
  logic [DIM_W:0] w_c, h_c;
  assign w_c = (int'(src_width)  > MAX_WIDTH)  ? (DIM_W+1)'(MAX_WIDTH)
                                               : {1'b0, src_width};
  assign h_c = (int'(src_height) > MAX_HEIGHT) ? (DIM_W+1)'(MAX_HEIGHT)
                                               : {1'b0, src_height};

  logic signed [PW-17:0] ix, iy;
  logic in_nxt;
  assign ix = px_r[PW-1:16];
  assign iy = py_r[PW-1:16];
  assign in_nxt = !ix[PW-17] && !iy[PW-17]
               && (ix < $signed({1'b0, (PW-17)'(w_c)}) - 1)
               && (iy < $signed({1'b0, (PW-17)'(h_c)}) - 1);

  always_ff @(posedge clk) begin
    if (adv) begin
      pxx_r <= PW'(coef_xx * $signed({1'b0, dx}));
      pxy_r <= PW'(coef_xy * $signed({1'b0, dy}));
      pyx_r <= PW'(coef_yx * $signed({1'b0, dx}));
      pyy_r <= PW'(coef_yy * $signed({1'b0, dy}));
      cxo_r <= coef_xo;
      cyo_r <= coef_yo;
      px_r  <= px_nxt;
      py_r  <= py_nxt;
      src_hit <= in_nxt;
      sx     <= ix[XW-1:0];
      sy     <= iy[YW-1:0];
      wx0    <= near_weight(px_r[15:0]);
      wy0    <= near_weight(py_r[15:0]);
    end
  end
endmodule
`default_nettype wire

// ----- rtl/awb_store.sv -----
// Pixel store: four banks split by x and y parity, one neighbour from each.
`default_nettype none
module awb_store import awb_pkg::*; #(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = MAX_HEIGHT_DEF,
  parameter int XW = $clog2(MAX_WIDTH),
  parameter int YW = $clog2(MAX_HEIGHT)
) (
  input  wire logic          clk,
  input  wire logic          adv,
  input  wire logic          wr_en,
  input  wire logic [XW-1:0] wr_x,
  input  wire logic [YW-1:0] wr_y,
  input  wire logic [31:0]   wr_data,
  input  wire logic [XW-1:0] rd_x,
  input  wire logic [YW-1:0] rd_y,
  output logic [31:0]        lt,
  output logic [31:0]        rt,
  output logic [31:0]        lb,
  output logic [31:0]        rb
);
  localparam int BX = (MAX_WIDTH + 1) / 2;
  localparam int BY = (MAX_HEIGHT + 1) / 2;
  localparam int BD = BX * BY;
  localparam int HXW = (XW > 1) ? XW - 1 : 1;
  localparam int HYW = (YW > 1) ? YW - 1 : 1;
  localparam int AW = $clog2(BD);

  logic [31:0] mem0 [BD];
  logic [31:0] mem1 [BD];
  logic [31:0] mem2 [BD];
  logic [31:0] mem3 [BD];

  function automatic logic [AW-1:0] baddr(input logic [XW:0] x, input logic [YW:0] y);
    logic [HXW:0] hx;
    logic [HYW:0] hy;
    hx = (HXW+1)'(x >> 1);
    hy = (HYW+1)'(y >> 1);
    return AW'(hy * BX + hx);
  endfunction

  logic [XW:0] x0, x1;
  logic [YW:0] y0, y1;
  logic [XW:0] xe, xo;
  logic [YW:0] ye, yo;
  assign x0 = {1'b0, rd_x};
  assign x1 = x0 + 1'b1;
  assign y0 = {1'b0, rd_y};
  assign y1 = y0 + 1'b1;
  assign xe = rd_x[0] ? x1 : x0;
  assign xo = rd_x[0] ? x0 : x1;
  assign ye = rd_y[0] ? y1 : y0;
  assign yo = rd_y[0] ? y0 : y1;

  logic [AW-1:0] wa;
  logic [1:0]    wb;
  assign wa = baddr({1'b0, wr_x}, {1'b0, wr_y});
  assign wb = {wr_y[0], wr_x[0]};

  logic [31:0] q0_r, q1_r, q2_r, q3_r;
  logic [1:0]  par_r;

  always_ff @(posedge clk) begin
    if (wr_en && wb == 2'd0) mem0[wa] <= wr_data;
    if (wr_en && wb == 2'd1) mem1[wa] <= wr_data;
    if (wr_en && wb == 2'd2) mem2[wa] <= wr_data;
    if (wr_en && wb == 2'd3) mem3[wa] <= wr_data;
    if (adv) begin
      q0_r  <= mem0[baddr(xe, ye)];
      q1_r  <= mem1[baddr(xo, ye)];
      q2_r  <= mem2[baddr(xe, yo)];
      q3_r  <= mem3[baddr(xo, yo)];
      par_r <= {rd_y[0], rd_x[0]};
    end
  end

  // route banks back to neighbour positions
  always_comb begin
    case (par_r)
      2'd0: begin lt = q0_r; rt = q1_r; lb = q2_r; rb = q3_r; end
      2'd1: begin lt = q1_r; rt = q0_r; lb = q3_r; rb = q2_r; end
      2'd2: begin lt = q2_r; rt = q3_r; lb = q0_r; rb = q1_r; end
      default: begin lt = q3_r; rt = q2_r; lb = q1_r; rb = q0_r; end
    endcase
  end
endmodule
`default_nettype wire

// ----- rtl/awb_blend.sv -----
// Blend stages: horizontal then vertical weighting of one channel.
`default_nettype none
module awb_blend import awb_pkg::*; (
  input  wire logic                clk,
  input  wire logic                adv,
  input  wire logic [7:0]          lt,
  input  wire logic [7:0]          rt,
  input  wire logic [7:0]          lb,
  input  wire logic [7:0]          rb,
  input  wire logic [WEIGHT_W-1:0] wx0,
  input  wire logic [WEIGHT_W-1:0] wy0,
  output logic [7:0]               pix
);
  logic [WEIGHT_W-1:0] wx1, wy1, wy0_r, wy1_r;
  logic [18:0] top_r, bot_r;
  assign wx1 = WEIGHT_W'(12'd2048) - wx0;
  assign wy1 = WEIGHT_W'(12'd2048) - wy0;

  logic [30:0] acc;
  assign acc = 31'(top_r * wy0_r) + 31'(bot_r * wy1_r);

  always_ff @(posedge clk) begin
    if (adv) begin
      top_r <= 19'(lt * wx0) + 19'(rt * wx1);
      bot_r <= 19'(lb * wx0) + 19'(rb * wx1);
      wy0_r <= wy0;
      wy1_r <= wy1;
      pix   <= acc[BLEND_SHIFT +: 8];
    end
  end
endmodule
`default_nettype wire

// ----- rtl/awb_checker.sv -----
// Checker: port-level properties of the affine warp block, bound to the top.
`default_nettype none
module awb_checker import awb_pkg::*; (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_stall,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire logic       out_inside_res,
  input wire logic [7:0] out_out_0,
  input wire logic [7:0] out_out_3
);
  a_stall_link: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall == (out_valid && out_stall)) else $error("input stall mismatch");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_out_0))
    else $error("stalled result changed");
  a_outside_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_inside_res |-> out_out_0 == 8'd0 && out_out_3 == 8'd0)
    else $error("outside result not zero");
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid) else $error("valid after reset");
endmodule

bind affine_warp_bilinear awb_checker u_awb_checker (
  .clk, .rst_n, .in_stall, .out_valid, .out_stall, .out_inside_res,
  .out_out_0, .out_out_3
);
`default_nettype wire

// ----- test/tb_affine_warp_bilinear.sv -----
// Testbench for the affine warp block: directed and random warps checked against a predictor.
`timescale 1ns / 100ps
`default_nettype none

module tb_affine_warp_bilinear;
  import awb_pkg::*;

  typedef struct packed {
    logic       hit;
    logic [7:0] ch3;
    logic [7:0] ch2;
    logic [7:0] ch1;
    logic [7:0] ch0;
  } warp_pixel_t;

  // Warp predictor: mirrors the register file and the pixel store, and keeps
  // the pixels expected on the result channel in order.
  class warp_scoreboard;
    logic signed [31:0] coef [6];
    logic [8:0]         width_reg, height_reg;
    logic [31:0]        store [MAX_WIDTH_DEF*MAX_HEIGHT_DEF];
    bit                 loaded [MAX_WIDTH_DEF*MAX_HEIGHT_DEF];
    warp_pixel_t        expected_pixels [$];
    int                 mismatches, results, inside_hits;

    function new();
      coef = '{32'sh10000, 0, 0, 0, 32'sh10000, 0};
      width_reg = 9'd256;
      height_reg = 9'd256;
      foreach (loaded[i]) loaded[i] = 0;
    endfunction

    function void set_reg(cfg_reg_t idx, logic [31:0] d);
      if (idx == REG_SRC_WIDTH) width_reg = d[8:0];
      else if (idx == REG_SRC_HEIGHT) height_reg = d[8:0];
      else coef[int'(idx)] = d;
    endfunction

    // Map (dx,dy) to the source grid; returns 1 when all four neighbours fit.
    function bit locate(logic [11:0] dx, logic [11:0] dy, output int sx, output int sy,
                        output logic [15:0] fx, output logic [15:0] fy);
      longint px, py, lx, ly, w, h, ldx, ldy;
      ldx = dx;
      ldy = dy;
      px = longint'(coef[0]) * ldx + longint'(coef[1]) * ldy + longint'(coef[2]);
      py = longint'(coef[3]) * ldx + longint'(coef[4]) * ldy + longint'(coef[5]);
      fx = px[15:0];
      fy = py[15:0];
      lx = px >>> 16;
      ly = py >>> 16;
      w = (width_reg > 9'd256) ? 256 : width_reg;
      h = (height_reg > 9'd256) ? 256 : height_reg;
      sx = int'(lx);
      sy = int'(ly);
      return !(lx < 0 || lx >= w - 1 || ly < 0 || ly >= h - 1);
    endfunction

    function void note_beat(mode_t m, logic [11:0] x, logic [11:0] y, logic [31:0] pix);
      int sx, sy, base;
      logic [15:0] fx, fy;
      longint wx0, wx1, wy0, wy1, acc;
      logic [7:0] ch [4];
      warp_pixel_t p;
      if (m == MODE_LOAD) begin
        // Drop loads outside the store; the fourth channel is not kept.
        if (x < 12'd256 && y < 12'd256) begin
          store[int'(y) * MAX_WIDTH_DEF + int'(x)] = {8'h00, pix[23:0]};
          loaded[int'(y) * MAX_WIDTH_DEF + int'(x)] = 1;
        end
        return;
      end
      p = '0;
      if (locate(x, y, sx, sy, fx, fy)) begin
        wy0 = ((65536 - longint'(fy)) + 16) >> 5;
        wy1 = 2048 - wy0;
        wx0 = ((65536 - longint'(fx)) + 16) >> 5;
        wx1 = 2048 - wx0;
        base = sy * MAX_WIDTH_DEF + sx;
        for (int k = 0; k < 4; k++) ch[k] = 8'h00;
        for (int k = 0; k < CHANNELS_DEF; k++) begin
          acc = longint'(store[base][8*k +: 8]) * wx0 * wy0
              + longint'(store[base + MAX_WIDTH_DEF][8*k +: 8]) * wx0 * wy1
              + longint'(store[base + 1][8*k +: 8]) * wx1 * wy0
              + longint'(store[base + MAX_WIDTH_DEF + 1][8*k +: 8]) * wx1 * wy1;
          ch[k] = acc[29:22];
        end
        p = {1'b1, ch[3], ch[2], ch[1], ch[0]};
      end
      expected_pixels.push_back(p);
    endfunction

    function void report(string what);
      mismatches++;
      $display("[%0t] mismatch: %s", $time, what);
    endfunction

    function void check_pixel(warp_pixel_t got);
      warp_pixel_t exp_p;
      results++;
      if (expected_pixels.size() == 0) begin
        report($sformatf("unexpected result %h", got));
        return;
      end
      exp_p = expected_pixels.pop_front();
      if (exp_p.hit) inside_hits++;
      if (got.hit !== exp_p.hit)
        report($sformatf("inside %b, want %b", got.hit, exp_p.hit));
      if (got.ch0 !== exp_p.ch0) report($sformatf("out_0 %h, want %h", got.ch0, exp_p.ch0));
      if (got.ch1 !== exp_p.ch1) report($sformatf("out_1 %h, want %h", got.ch1, exp_p.ch1));
      if (got.ch2 !== exp_p.ch2) report($sformatf("out_2 %h, want %h", got.ch2, exp_p.ch2));
      if (got.ch3 !== exp_p.ch3) report($sformatf("out_3 %h, want %h", got.ch3, exp_p.ch3));
    endfunction
  endclass

  logic                  clk = 0;
  logic                  rst_n = 0;
  logic                  cfg_we = 0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_valid = 0;
  logic                  in_stall;
  logic                  in_mode = 0;
  logic [COORD_W-1:0]    in_coord_x = '0, in_coord_y = '0;
  logic [7:0]            in_value_0 = '0, in_value_1 = '0, in_value_2 = '0, in_value_3 = '0;
  logic                  out_valid;
  logic                  out_stall = 0;
  logic                  out_inside_res;
  logic [7:0]            out_out_0, out_out_1, out_out_2, out_out_3;

  warp_scoreboard sb = new();
  bit  quiet = 0;        // no idling on either side
  bit  hold_req = 0;     // ask the receiver for one long hold-off
  int  loads_sent = 0, requests_sent = 0, phases_run = 0, idle_cycles = 0;

  always #2 clk = ~clk;

  affine_warp_bilinear u_dut (
    .clk, .rst_n, .cfg_we, .cfg_index, .cfg_data,
    .in_valid, .in_stall, .in_mode, .in_coord_x, .in_coord_y,
    .in_value_0, .in_value_1, .in_value_2, .in_value_3,
    .out_valid, .out_stall, .out_inside_res,
    .out_out_0, .out_out_1, .out_out_2, .out_out_3
  );

  // Check result beats at the falling edge, where everything has settled.
  always @(negedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_pixel({out_inside_res, out_out_3, out_out_2, out_out_1, out_out_0});
  end

  // Watchdog: end the run when no beat moves on either channel for too long.
  always @(negedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= 4000) begin
        $display("timeout: no beat accepted for %0d cycles", idle_cycles);
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  // Receiver: random stall bursts, one long hold-off on request, none when quiet.
  initial begin
    @(posedge rst_n);
    @(posedge clk);
    forever begin
      if (hold_req) begin
        out_stall <= 1;
        repeat (300) @(posedge clk);
        hold_req = 0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        out_stall <= 1;
        repeat ($urandom_range(1, 7)) @(posedge clk);
      end else begin
        out_stall <= 0;
        @(posedge clk);
      end
    end
  end

  // Offer one beat and hold it until accepted; called and returns at a rising edge.
  task automatic send_beat(mode_t m, logic [11:0] x, logic [11:0] y, logic [31:0] pix);
    bit took;
    in_valid <= 1;
    in_mode <= m;
    in_coord_x <= x;
    in_coord_y <= y;
    {in_value_3, in_value_2, in_value_1, in_value_0} <= pix;
    do begin
      @(negedge clk);
      took = !in_stall;
      if (took) sb.note_beat(m, x, y, pix);
      @(posedge clk);
    end while (!took);
    if (m == MODE_LOAD) loads_sent++;
    else requests_sent++;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
  endtask

  task automatic load_pixel(int x, int y);
    send_beat(MODE_LOAD, x[11:0], y[11:0], $urandom);
  endtask

  // Request (dx,dy), loading any neighbour it would read that is still unknown.
  task automatic request_pixel(logic [11:0] dx, logic [11:0] dy);
    int sx, sy;
    logic [15:0] fx, fy;
    if (sb.locate(dx, dy, sx, sy, fx, fy)) begin
      for (int j = 0; j < 2; j++)
        for (int i = 0; i < 2; i++)
          if (!sb.loaded[(sy + j) * MAX_WIDTH_DEF + sx + i]) load_pixel(sx + i, sy + j);
    end
    send_beat(MODE_REQUEST, dx, dy, $urandom);
  endtask

  // Drain the pipeline, then write all registers back to back.
  task automatic configure(logic [31:0] c0, logic [31:0] c1, logic [31:0] c2,
                           logic [31:0] c3, logic [31:0] c4, logic [31:0] c5,
                           logic [8:0] w, logic [8:0] h);
    logic [31:0] vals [8];
    in_valid <= 0;
    @(posedge clk);
    while (sb.expected_pixels.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    vals = '{c0, c1, c2, c3, c4, c5,
             {23'($urandom_range(0, 8388607)), w}, {23'($urandom_range(0, 8388607)), h}};
    for (int i = 0; i < 8; i++) begin
      cfg_we <= 1;
      cfg_index <= cfg_reg_t'(i);
      cfg_data <= vals[i];
      sb.set_reg(cfg_reg_t'(i), vals[i]);
      @(posedge clk);
    end
    cfg_we <= 0;
    @(posedge clk);
    phases_run++;
  endtask

  function automatic logic [31:0] pick_extreme();
    case ($urandom_range(0, 4))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'hFFFF_FFFF;
      3: return 32'h0001_0000;
      default: return 32'h0;
    endcase
  endfunction

  initial begin
    int w, h, dmax, r;
    repeat (6) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // Directed: corner loads with extreme bytes, ignored loads, edge requests.
    send_beat(MODE_LOAD, 12'd0, 12'd0, 32'h0000_0000);
    send_beat(MODE_LOAD, 12'd1, 12'd0, 32'hFFFF_FFFF);
    send_beat(MODE_LOAD, 12'd0, 12'd1, 32'hA5FF_00FF);
    send_beat(MODE_LOAD, 12'd1, 12'd1, 32'h5A00_FF00);
    send_beat(MODE_LOAD, 12'd4095, 12'd4095, 32'hFFFF_FFFF);
    send_beat(MODE_LOAD, 12'd256, 12'd0, 32'h1234_5678);
    send_beat(MODE_LOAD, 12'd0, 12'd256, 32'h8765_4321);
    request_pixel(12'd0, 12'd0);
    request_pixel(12'd254, 12'd254);
    request_pixel(12'd255, 12'd0);
    request_pixel(12'd0, 12'd255);
    request_pixel(12'd4095, 12'd4095);
    // Half-pixel offset: equal weights on both neighbours.
    configure(32'h10000, 0, 32'h8000, 0, 32'h10000, 32'h8000, 9'd256, 9'd256);
    request_pixel(12'd0, 12'd0);
    request_pixel(12'd253, 12'd253);
    // Tiny image: everything outside.
    configure(32'h10000, 0, 0, 0, 32'h10000, 0, 9'd1, 9'd0);
    request_pixel(12'd0, 12'd0);
    // Oversize dimensions saturate to the store size.
    configure(32'h10000, 0, 0, 0, 32'h10000, 0, 9'd511, 9'd300);
    request_pixel(12'd254, 12'd0);
    request_pixel(12'd255, 12'd3);
    // Extreme coefficients: far outside on both sides.
    configure(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
              32'h7FFF_FFFF, 32'h8000_0000, 9'd2, 9'd2);
    request_pixel(12'd4095, 12'd4095);
    request_pixel(12'd1, 12'd0);

    // Random phases, each under its own warp.
    for (int p = 0; p < 10; p++) begin
      case (p % 5)
        0: begin
          w = $urandom_range(2, 300); h = $urandom_range(2, 300); dmax = 60;
          configure($urandom_range(32'h4000, 32'h20000), $urandom_range(0, 32'h8000) - 32'h4000,
                    $urandom_range(0, 32'h40000), $urandom_range(0, 32'h8000) - 32'h4000,
                    $urandom_range(32'h4000, 32'h20000), $urandom_range(0, 32'h40000),
                    9'(w), 9'(h));
        end
        1: begin
          w = $urandom_range(2, 32); h = $urandom_range(2, 32); dmax = 40;
          configure(32'hFFFF_0000, 0, ((w - 1) << 16) - 1, 0, 32'hFFFF_0000,
                    ((h - 1) << 16) - $urandom_range(1, 65535), 9'(w), 9'(h));
        end
        2: begin
          r = $urandom_range(0, 4);
          w = (r == 0) ? 0 : (r == 1) ? 1 : (r == 2) ? 2 : (r == 3) ? 256 : 511;
          h = $urandom_range(0, 511); dmax = 4095;
          configure(pick_extreme(), pick_extreme(), pick_extreme(), pick_extreme(),
                    pick_extreme(), pick_extreme(), 9'(w), 9'(h));
        end
        3: begin
          w = 2; h = $urandom_range(2, 3); dmax = 50;
          configure($urandom_range(0, 32'h400), $urandom_range(0, 32'h200),
                    $urandom_range(0, 32'hFFFF), $urandom_range(0, 32'h200),
                    $urandom_range(0, 32'h400), $urandom_range(0, 32'hFFFF), 9'(w), 9'(h));
        end
        default: begin
          w = $urandom_range(2, 256); h = $urandom_range(2, 256); dmax = 80;
          configure($urandom_range(0, 32'h40000) - 32'h20000,
                    $urandom_range(0, 32'h40000) - 32'h20000, $urandom_range(0, 32'h800000),
                    $urandom_range(0, 32'h40000) - 32'h20000,
                    $urandom_range(0, 32'h40000) - 32'h20000, $urandom_range(0, 32'h800000),
                    9'(w), 9'(h));
        end
      endcase
      quiet = (p == 9) || (p % 3 == 2);
      for (int n = 0; n < 100; n++) begin
        if (p == 1 && n == 30) hold_req = 1;
        r = $urandom_range(0, 99);
        if (r < 70) begin
          if ($urandom_range(0, 9) < 8)
            request_pixel(12'($urandom_range(0, dmax)), 12'($urandom_range(0, dmax)));
          else
            request_pixel(12'($urandom_range(0, 4095)), 12'($urandom_range(0, 4095)));
        end else if (r < 90) begin
          load_pixel($urandom_range(0, (w > 1 && w < 256) ? w - 1 : 255),
                     $urandom_range(0, (h > 1 && h < 256) ? h - 1 : 255));
        end else begin
          load_pixel($urandom_range(0, 4095), $urandom_range(0, 4095));
        end
      end
    end

    // Wait out the last results, then the pipeline latency.
    in_valid <= 0;
    @(posedge clk);
    while (sb.expected_pixels.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("covered %0d loads and %0d requests over %0d register settings",
             loads_sent, requests_sent, phases_run);
    $display("checked %0d result beats, %0d inside the source image",
             sb.results, sb.inside_hits);
    if (sb.mismatches == 0 && sb.expected_pixels.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule

`default_nettype wire
